// ===== hdl/bkbc_pkg.sv =====
package bkbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    KIND_PAREN,
    KIND_BRACKET,
    KIND_BRACE,
    KIND_KEYWORD
  } kind_t;

  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  clear;
    kind_t kind;
  } stk_cmd_t;

  typedef struct packed {
    logic  empty;
    logic  one;
    logic  full;
    kind_t top;
  } stk_stat_t;

endpackage

// ===== hdl/bkbc_stack.sv =====
module bkbc_stack (
  input  logic               clk,
  input  logic               rst_n,
  input  bkbc_pkg::stk_cmd_t cmd,
  output bkbc_pkg::stk_stat_t stat
);

  logic [bkbc_pkg::CNT_W-1:0]  count_r, count_nxt;
  bkbc_pkg::kind_t             top_r, top_nxt;
  bkbc_pkg::kind_t             below_r;
  logic [bkbc_pkg::ADDR_W-1:0] rd_addr;
  logic                        full;
  logic                        push_ok;

  bkbc_pkg::kind_t mem [bkbc_pkg::STACK_DEPTH];

  assign full    = (count_r == bkbc_pkg::CNT_W'(bkbc_pkg::STACK_DEPTH));
  assign push_ok = cmd.push && !full;

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (push_ok) begin
      count_nxt = count_r + bkbc_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - bkbc_pkg::CNT_W'(1);
    end
    if (push_ok) begin
      top_nxt = cmd.kind;
    end else if (cmd.pop) begin
      top_nxt = below_r;
    end
  end

  // prefetch the entry under the next top; never the address written this cycle, except when a clear comes with a push
  assign rd_addr = bkbc_pkg::ADDR_W'(count_nxt - bkbc_pkg::CNT_W'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[count_r[bkbc_pkg::ADDR_W-1:0]] <= cmd.kind;
    end
    below_r <= mem[rd_addr];
  end

  assign stat.empty = (count_r == '0);
  assign stat.one   = (count_r == bkbc_pkg::CNT_W'(1));
  assign stat.full  = full;
  assign stat.top   = top_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bkbc_pkg::CNT_W'(bkbc_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  a_full_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push && full && !cmd.clear |=> $stable(count_r))
    else $error("push on full stack changed count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.empty)
    else $error("pop on empty stack");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0)
    else $error("clear left entries on stack");

endmodule

// ===== hdl/bracket_keyword_balance_checker_unit.sv =====
// Checks nesting of (), [], {} and begin/end over a byte stream, one item per clock
// cycle. An input item is taken whenever the result register is empty or its result
// is being taken in the same cycle, so a stream flows at one byte per cycle. The
// item marked tlast yields one result in the following cycle: balanced and
// overflowed. The stack sits in a single-port-write, one-read RAM of STACK_DEPTH
// two-bit entries; the top entry is held in a register for the per-byte compare and
// the entry beneath it is prefetched every cycle, which is what allows a pop to
// follow a pop without a bubble. The RAM needs no clearing pass: the entry count
// resets to zero and only entries below it are read.
module bracket_keyword_balance_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // balanced, overflowed, zero fill
);

  logic                  acc;
  logic                  sep;
  logic                  begin_hit, end_hit;
  logic                  open_hit, close_hit;
  bkbc_pkg::kind_t       kind;
  logic                  push_req, close_req, pop_ok;
  logic                  mis_after, ovf_after, zero_after;
  logic                  mismatch_r, mismatch_nxt;
  logic                  overflow_r, overflow_nxt;
  logic [2:0]            fill_r, fill_nxt;
  logic [7:0]            recent_r [4];
  logic [7:0]            recent_nxt [4];
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_data_r, out_data_nxt;
  bkbc_pkg::stk_cmd_t    cmd;
  bkbc_pkg::stk_stat_t   stat;

  assign in_tready = out_tready || !out_valid_r;
  assign acc       = in_tvalid && in_tready;

  assign sep = (in_tdata == bkbc_pkg::CH_SPACE) ||
               ((in_tdata >= bkbc_pkg::CH_TAB) && (in_tdata <= bkbc_pkg::CH_CR));

  assign begin_hit = (in_tdata == bkbc_pkg::CH_N) && (fill_r >= 3'd4) &&
                     (recent_r[0] == bkbc_pkg::CH_B) && (recent_r[1] == bkbc_pkg::CH_E) &&
                     (recent_r[2] == bkbc_pkg::CH_G) && (recent_r[3] == bkbc_pkg::CH_I);
  assign end_hit   = (in_tdata == bkbc_pkg::CH_D) && (fill_r >= 3'd2) &&
                     (recent_r[2] == bkbc_pkg::CH_E) && (recent_r[3] == bkbc_pkg::CH_N);

  always_comb begin
    open_hit  = 1'b0;
    close_hit = 1'b0;
    kind      = bkbc_pkg::KIND_KEYWORD;
    case (in_tdata)
      bkbc_pkg::CH_LPAREN: begin
        open_hit = 1'b1;
        kind     = bkbc_pkg::KIND_PAREN;
      end
      bkbc_pkg::CH_LBRACK: begin
        open_hit = 1'b1;
        kind     = bkbc_pkg::KIND_BRACKET;
      end
      bkbc_pkg::CH_LBRACE: begin
        open_hit = 1'b1;
        kind     = bkbc_pkg::KIND_BRACE;
      end
      bkbc_pkg::CH_RPAREN: begin
        close_hit = 1'b1;
        kind      = bkbc_pkg::KIND_PAREN;
      end
      bkbc_pkg::CH_RBRACK: begin
        close_hit = 1'b1;
        kind      = bkbc_pkg::KIND_BRACKET;
      end
      bkbc_pkg::CH_RBRACE: begin
        close_hit = 1'b1;
        kind      = bkbc_pkg::KIND_BRACE;
      end
      default: begin
        open_hit  = begin_hit;
        close_hit = end_hit;
        kind      = bkbc_pkg::KIND_KEYWORD;
      end
    endcase
  end

  assign push_req  = acc && !sep && open_hit;
  assign close_req = acc && !sep && close_hit;
  assign pop_ok    = close_req && !stat.empty && (stat.top == kind);

  assign mis_after  = mismatch_r || (close_req && !pop_ok) || (push_req && stat.full);
  assign ovf_after  = overflow_r || (push_req && stat.full);
  assign zero_after = pop_ok ? stat.one : ((push_req && !stat.full) ? 1'b0 : stat.empty);

  assign cmd.push  = push_req;
  assign cmd.pop   = pop_ok;
  assign cmd.clear = acc && in_tlast;
  assign cmd.kind  = kind;

  always_comb begin
    mismatch_nxt  = mismatch_r;
    overflow_nxt  = overflow_r;
    fill_nxt      = fill_r;
    recent_nxt    = recent_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (acc) begin
      mismatch_nxt = mis_after;
      overflow_nxt = ovf_after;
      if (sep) begin
        fill_nxt = 3'd0;
      end else begin
        recent_nxt[0] = recent_r[1];
        recent_nxt[1] = recent_r[2];
        recent_nxt[2] = recent_r[3];
        recent_nxt[3] = in_tdata;
        if (fill_r != 3'd7) begin
          fill_nxt = fill_r + 3'd1;
        end
      end
      if (in_tlast) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {ovf_after, zero_after && !mis_after};
        mismatch_nxt  = 1'b0;
        overflow_nxt  = 1'b0;
        fill_nxt      = 3'd0;
        recent_nxt    = '{default: 8'h00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mismatch_r  <= 1'b0;
      overflow_r  <= 1'b0;
      fill_r      <= 3'd0;
      recent_r    <= '{default: 8'h00};
      out_valid_r <= 1'b0;
    end else begin
      mismatch_r  <= mismatch_nxt;
      overflow_r  <= overflow_nxt;
      fill_r      <= fill_nxt;
      recent_r    <= recent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  bkbc_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_data_r};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result lost or changed");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> !mismatch_r && !overflow_r && fill_r == 3'd0)
    else $error("state not cleared after last item");

  a_ovf_implies_mis: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |-> mismatch_r)
    else $error("overflow without error flag");

endmodule

// ===== test/tb_top.sv =====
module tb_top;

  typedef struct packed {
    logic balanced;
    logic overflowed;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  // shadow copy of the nesting state
  bkbc_pkg::kind_t nest_q [bkbc_pkg::STACK_DEPTH];
  int         nest_n = 0;
  bit         err_f = 1'b0;
  bit         ovf_f = 1'b0;
  logic [7:0] hist [4] = '{default: '0};
  int         tok_len = 0;

  verdict_t   verdict_q [$];
  logic [7:0] text_q [$];
  int         errors = 0;
  int         items_sent = 0;
  bit         in_idle_en = 1'b0;
  bit         out_idle_en = 1'b0;

  bracket_keyword_balance_checker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function void push_nest(input bkbc_pkg::kind_t k);
    if (nest_n >= bkbc_pkg::STACK_DEPTH) begin
      err_f = 1'b1;
      ovf_f = 1'b1;
    end else begin
      nest_q[nest_n] = k;
      nest_n++;
    end
  endfunction

  function void pop_nest(input bkbc_pkg::kind_t k);
    if (nest_n == 0) begin
      err_f = 1'b1;
    end else if (nest_q[nest_n-1] == k) begin
      nest_n--;
    end else begin
      err_f = 1'b1;
    end
  endfunction

  function void predict_char(input logic [7:0] c, input logic last);
    logic     begin_hit;
    logic     end_hit;
    verdict_t want;
    if (c == bkbc_pkg::CH_SPACE || (c >= bkbc_pkg::CH_TAB && c <= bkbc_pkg::CH_CR)) begin
      tok_len = 0;
    end else begin
      begin_hit = c == bkbc_pkg::CH_N && tok_len >= 4 &&
                  hist[0] == bkbc_pkg::CH_B && hist[1] == bkbc_pkg::CH_E &&
                  hist[2] == bkbc_pkg::CH_G && hist[3] == bkbc_pkg::CH_I;
      end_hit = c == bkbc_pkg::CH_D && tok_len >= 2 &&
                hist[2] == bkbc_pkg::CH_E && hist[3] == bkbc_pkg::CH_N;
      if (begin_hit) begin
        push_nest(bkbc_pkg::KIND_KEYWORD);
      end else if (end_hit) begin
        pop_nest(bkbc_pkg::KIND_KEYWORD);
      end else begin
        case (c)
          bkbc_pkg::CH_LPAREN: push_nest(bkbc_pkg::KIND_PAREN);
          bkbc_pkg::CH_LBRACK: push_nest(bkbc_pkg::KIND_BRACKET);
          bkbc_pkg::CH_LBRACE: push_nest(bkbc_pkg::KIND_BRACE);
          bkbc_pkg::CH_RPAREN: pop_nest(bkbc_pkg::KIND_PAREN);
          bkbc_pkg::CH_RBRACK: pop_nest(bkbc_pkg::KIND_BRACKET);
          bkbc_pkg::CH_RBRACE: pop_nest(bkbc_pkg::KIND_BRACE);
          default: ;
        endcase
      end
      hist[0] = hist[1];
      hist[1] = hist[2];
      hist[2] = hist[3];
      hist[3] = c;
      if (tok_len < 7) tok_len++;
    end
    if (last) begin
      want.balanced = (nest_n == 0) && !err_f;
      want.overflowed = ovf_f;
      verdict_q.push_back(want);
      nest_n = 0;
      err_f = 1'b0;
      ovf_f = 1'b0;
      hist = '{default: '0};
      tok_len = 0;
    end
  endfunction

  // results are checked before new items are predicted in the same cycle
  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (out_tdata[0] !== want.balanced) begin
            $display("%0t: balanced mismatch, expected %0b actual %0b",
                     $time, want.balanced, out_tdata[0]);
            errors++;
          end
          if (out_tdata[1] !== want.overflowed) begin
            $display("%0t: overflowed mismatch, expected %0b actual %0b",
                     $time, want.overflowed, out_tdata[1]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
    end
  end

  // result side stalls once a result shows up
  initial begin : sink
    int n;
    forever begin
      n = out_idle_en ? $urandom_range(0, 8) : 0;
      if (n > 0) begin
        out_tready <= 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (n - 1) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #400000;
    $display("bracket_keyword_balance_checker_unit verification failed");
    $finish;
  end

  function void add_byte(input logic [7:0] b);
    text_q.push_back(b);
  endfunction

  function void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function void add_sep();
    int r;
    r = $urandom_range(9, 14);
    add_byte(r == 14 ? bkbc_pkg::CH_SPACE : 8'(r));
  endfunction

  function void add_kind(input bkbc_pkg::kind_t k, input bit opening);
    case (k)
      bkbc_pkg::KIND_PAREN:
        add_byte(opening ? bkbc_pkg::CH_LPAREN : bkbc_pkg::CH_RPAREN);
      bkbc_pkg::KIND_BRACKET:
        add_byte(opening ? bkbc_pkg::CH_LBRACK : bkbc_pkg::CH_RBRACK);
      bkbc_pkg::KIND_BRACE:
        add_byte(opening ? bkbc_pkg::CH_LBRACE : bkbc_pkg::CH_RBRACE);
      default: begin
        if ($urandom_range(0, 1) != 0) add_sep();
        add_str(opening ? "begin" : "end");
        if ($urandom_range(0, 1) != 0) add_sep();
      end
    endcase
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = in_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    add_str("([{}])");
    send_text();
    add_str("begin");
    add_byte(bkbc_pkg::CH_TAB);
    add_str("x");
    add_byte(8'h0a);
    add_str("end");
    send_text();
    // split keyword is not a keyword, so the end is a closer on empty stack
    add_str("beg");
    add_byte(8'h0b);
    add_str("in");
    add_byte(8'h0c);
    add_str("end");
    add_byte(bkbc_pkg::CH_SPACE);
    send_text();
    add_str("(en");
    add_byte(bkbc_pkg::CH_CR);
    add_str("d)");
    send_text();
    add_str("b");
    add_byte(bkbc_pkg::CH_SPACE);
    add_str("egin");
    send_text();
    add_str(")");
    send_text();
    add_str("(])");
    send_text();
    add_str("xxxxbeginend");
    send_text();
    add_byte(8'h00);
    add_byte(8'hff);
    send_text();
    add_str("(");
    send_text();
  endtask

  task automatic test_overflow();
    repeat (bkbc_pkg::STACK_DEPTH) add_byte(bkbc_pkg::CH_LPAREN);
    repeat (bkbc_pkg::STACK_DEPTH) add_byte(bkbc_pkg::CH_RPAREN);
    send_text();
    repeat (bkbc_pkg::STACK_DEPTH) add_byte(bkbc_pkg::CH_LBRACK);
    add_str("begin");
    repeat (bkbc_pkg::STACK_DEPTH) add_byte(bkbc_pkg::CH_RBRACK);
    send_text();
    repeat (bkbc_pkg::STACK_DEPTH + 1) add_byte(bkbc_pkg::CH_LBRACE);
    add_str("x");
    send_text();
    add_str("()");
    send_text();
  endtask

  task automatic build_random_text();
    bkbc_pkg::kind_t open_k [$];
    int    span;
    int    r;
    bit    tidy;
    bit    deep;
    string letters;
    letters = "begindxyz";
    deep = ($urandom_range(0, 39) == 0);
    tidy = ($urandom_range(0, 4) != 0);
    span = deep ? 140 : $urandom_range(1, 24);
    repeat (span) begin
      r = $urandom_range(0, 99);
      if (r < (deep ? 60 : 28)) begin
        open_k.push_back(bkbc_pkg::kind_t'($urandom_range(0, 3)));
        add_kind(open_k[$], 1'b1);
      end else if (r < 55 && open_k.size() != 0) begin
        add_kind(open_k.pop_back(), 1'b0);
      end else if (r < 70) begin
        add_byte(letters[$urandom_range(0, letters.len() - 1)]);
      end else if (r < 88) begin
        add_sep();
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
    if (tidy) begin
      while (open_k.size() != 0) add_kind(open_k.pop_back(), 1'b0);
    end
    if (text_q.size() == 0) add_sep();
  endtask

  task automatic test_random();
    int  first;
    bit  paused;
    first = items_sent;
    paused = 1'b0;
    while (items_sent - first < 500) begin
      in_idle_en = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      build_random_text();
      send_text();
      if (!paused && items_sent - first > 250) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    drain_results();
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    test_overflow();
    test_random();
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("bracket_keyword_balance_checker_unit verification clean");
    end else begin
      $display("bracket_keyword_balance_checker_unit verification failed");
    end
    $finish;
  end

endmodule
